[rtl/b64_pkg.sv]
package b64_pkg;

  localparam int CountWidth = 13;
  localparam int MaxOutBytesDefault = 4096;
  localparam int CountCap = 8191;
  localparam logic [CountWidth-1:0] OutLimitReset = 13'd2048;

  typedef struct packed {
    logic       bad;
    logic [5:0] val;
  } sextet_t;

  typedef struct packed {
    logic [7:0]            data_byte;
    logic                  is_end;
    logic [CountWidth-1:0] byte_count;
  } result_t;

  typedef struct packed {
    result_t [2:0] ent;
    logic [1:0]    num;
  } bundle_t;

  function automatic sextet_t sextet(input logic [7:0] ch);
    sextet_t s;
    s.bad = 1'b0;
    s.val = 6'd63;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      s.val = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7a) begin
      s.val = 6'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.val = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2b) begin
      s.val = 6'd62;
    end else if (ch == 8'h2f) begin
      s.val = 6'd63;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

[rtl/b64_dec_core.sv]
module b64_dec_core #(
  parameter int MAX_OUT_BYTES = b64_pkg::MaxOutBytesDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [b64_pkg::CountWidth-1:0] cfg_data,
  input  logic                          accept,
  input  logic [7:0]                    char_code,
  output logic                          load,
  output b64_pkg::bundle_t              bundle
);
  import b64_pkg::*;

  localparam int LimCap = (MAX_OUT_BYTES < CountCap) ? MAX_OUT_BYTES : CountCap;
  localparam logic [CountWidth-1:0] LimCapW = CountWidth'(LimCap);

  logic [CountWidth-1:0] out_limit;
  logic [5:0]            vals [3];
  logic [2:0]            inv;
  logic [1:0]            pos;
  logic [CountWidth-1:0] bw;
  logic                  stopped;

  sextet_t               sx;
  logic [CountWidth-1:0] lim;
  logic [CountWidth-1:0] bw1, bw2, bw_next;
  logic                  e0, e1, e2;
  logic [7:0]            b0, b1, b2;
  logic                  is_zero, is_fourth;

  always_comb begin
    sx        = sextet(char_code);
    lim       = (out_limit > LimCapW) ? LimCapW : out_limit;
    is_zero   = (char_code == 8'd0);
    is_fourth = !is_zero && !stopped && (pos == 2'd3) && !inv[0] && !inv[1];
    b0 = {vals[0], vals[1][5:4]};
    b1 = {vals[1][3:0], vals[2][5:2]};
    b2 = {vals[2][1:0], sx.val};
    e0  = is_fourth && (bw < lim);
    bw1 = bw + CountWidth'(e0);
    e1  = is_fourth && !inv[2] && (bw1 < lim);
    bw2 = bw1 + CountWidth'(e1);
    e2  = is_fourth && !sx.bad && (bw2 < lim);
    bw_next = bw2 + CountWidth'(e2);

    bundle = '0;
    if (is_zero) begin
      bundle.num = 2'd1;
      bundle.ent[0] = '{data_byte: 8'd0, is_end: 1'b1, byte_count: bw};
    end else begin
      bundle.num = 2'(e0) + 2'(e1) + 2'(e2);
      bundle.ent[0] = '{data_byte: b0, is_end: 1'b0, byte_count: bw + 13'd1};
      bundle.ent[1] = '{data_byte: e1 ? b1 : b2, is_end: 1'b0, byte_count: bw + 13'd2};
      bundle.ent[2] = '{data_byte: b2, is_end: 1'b0, byte_count: bw + 13'd3};
    end
    load = accept && (bundle.num != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= OutLimitReset;
      pos       <= 2'd0;
      bw        <= '0;
      stopped   <= 1'b0;
      inv       <= '0;
    end else begin
      if (cfg_write) begin
        out_limit <= cfg_data;
      end
      if (accept) begin
        if (is_zero) begin
          pos     <= 2'd0;
          bw      <= '0;
          stopped <= 1'b0;
          inv     <= '0;
        end else if (!stopped) begin
          if (pos != 2'd3) begin
            inv[pos] <= sx.bad;
            pos      <= pos + 2'd1;
          end else begin
            pos <= 2'd0;
            if (inv[0] || inv[1]) begin
              stopped <= 1'b1;
            end else begin
              bw <= bw_next;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_zero && !stopped && pos != 2'd3) begin
      vals[pos] <= sx.val;
    end
  end

endmodule

[rtl/b64_out_ser.sv]
module b64_out_ser (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  b64_pkg::bundle_t bundle,
  output logic             can_load,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [23:0]      m_tdata,
  output logic             m_tuser,
  output logic             m_tlast
);
  import b64_pkg::*;

  bundle_t    held;
  logic [1:0] idx;
  logic       valid;
  logic       is_last;
  result_t    cur;

  always_comb begin
    cur      = held.ent[idx];
    is_last  = (idx == 2'(held.num - 2'd1));
    can_load = !valid || (m_tready && is_last);
    m_tvalid = valid;
    m_tdata  = {3'd0, cur.byte_count, cur.data_byte};
    m_tuser  = cur.is_end;
    m_tlast  = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (valid && m_tready) begin
      if (is_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle;
    end
  end

endmodule

[rtl/base64_stream_decoder_top.sv]
// Results: a result is registered and appears in the cycle after its character is accepted.
// Throughput: one character per cycle while the output is not stalled; a character that
//   yields several results holds s_tready low until the result register drains its last one.
// Reset: synchronous, active high; clears group state and byte count and
//   loads out_limit with 2048. No clearing pass.
module base64_stream_decoder_top #(
  parameter int MAX_OUT_BYTES = b64_pkg::MaxOutBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data,   // out_limit
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // char_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // data_byte[7:0], byte_count[20:8], zero fill
  output logic        m_tuser,    // is_end
  output logic        m_tlast
);
  import b64_pkg::*;

  bundle_t bundle;
  logic    load;
  logic    can_load;

  assign cfg_ready = 1'b1;
  assign s_tready  = can_load;

  b64_dec_core #(
    .MAX_OUT_BYTES(MAX_OUT_BYTES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_valid),
    .cfg_data (cfg_data),
    .accept   (s_tvalid && can_load),
    .char_code(s_tdata),
    .load     (load),
    .bundle   (bundle)
  );

  b64_out_ser u_ser (
    .clk     (clk),
    .rst     (rst),
    .load    (load),
    .bundle  (bundle),
    .can_load(can_load),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

[rtl/b64_dec_checker.sv]
module b64_dec_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  a_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (m_tdata[7:0] == 8'd0))
    else $error("end result malformed");

  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && !m_tuser && (m_tdata[20:8] == 13'($past(m_tdata[20:8]) + 13'd1)))
    else $error("byte count did not advance within a burst");

  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown after reset");

endmodule

bind base64_stream_decoder_top b64_dec_checker u_chk (.*);
